/* design/tgapsd_pkg.sv */
`default_nettype none

package tgapsd_pkg;

	// image geometry limits
	localparam int MAX_SIDE  = 4096;
	localparam int MIN_WIDTH = 4;
	localparam int MIN_HEIGHT = 1;
	localparam int POS_W     = $clog2(MAX_SIDE);
	localparam int SIDE_W    = $clog2(MAX_SIDE) + 1;

	// fixed field widths
	localparam int BYTE_W     = 8;
	localparam int ADDR_W     = 24;
	localparam int LEN_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int BPP_W      = 3;
	localparam int BIP_W      = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BPP      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd3;

	// register reset values
	localparam logic             RST_RLE_MODE = 1'b1;
	localparam logic [BPP_W-1:0] RST_BPP      = 3'd3;
	localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 13'd1024;
	localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 13'd512;

	// bytes per pixel code selecting the alpha byte
	localparam logic [BPP_W-1:0] BPP_WITH_ALPHA = 3'd4;

	// packet header layout
	localparam logic [6:0] PKT_LEN_MASK = 7'h7F;

	// byte positions inside a pixel
	localparam logic [BIP_W-1:0] BIP_BLUE  = 2'd0;
	localparam logic [BIP_W-1:0] BIP_GREEN = 2'd1;
	localparam logic [BIP_W-1:0] BIP_RED   = 2'd2;
	localparam logic [BIP_W-1:0] BIP_ALPHA = 2'd3;

	// command queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	// one pixel group to place
	typedef struct packed {
		logic              restart;
		logic [LEN_W-1:0]  count;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] alpha;
	} cmd_t;

	// decode format seen by the front end
	typedef struct packed {
		logic rle_mode;
		logic four_bytes;
	} fmt_t;

	// clamped geometry seen by the back end
	typedef struct packed {
		logic [SIDE_W-1:0] width;
		logic [SIDE_W-1:0] height;
	} geom_t;

	// one span result
	typedef struct packed {
		logic [ADDR_W-1:0] start_address;
		logic [LEN_W-1:0]  span_length;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] alpha;
		logic              last_of_run;
		logic              image_done;
		logic              overrun;
	} res_t;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_DATA_W-1:0] v,
		input int lo);
		logic [SIDE_W-1:0] r;
		if (v < CFG_DATA_W'(lo)) begin
			r = SIDE_W'(lo);
		end else if (v > CFG_DATA_W'(MAX_SIDE)) begin
			r = SIDE_W'(MAX_SIDE);
		end else begin
			r = SIDE_W'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/tgapsd_front.sv */
`default_nettype none

module tgapsd_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tgapsd_pkg::fmt_t          fmt,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [7:0]                data_byte,
	input  wire logic                      first_byte,
	input  wire logic                      fifo_full,
	output logic                           push,
	output tgapsd_pkg::cmd_t               push_cmd
);
	import tgapsd_pkg::*;

	logic [LEN_W-1:0]     packet_left_q, left_n;
	logic                 packet_repeat_q, repeat_n;
	logic                 awaiting_q, awaiting_n;
	logic [BIP_W-1:0]     bip_q, bip_n;
	logic [3*BYTE_W-1:0]  pixel_q, pixel_n;
	logic                 restart_pend_q, pend_n;
	logic                 accept;
	logic [BIP_W-1:0]     last_bip;
	logic [BYTE_W-1:0]    alpha_c;
	logic [LEN_W-1:0]     count_c;
	logic                 done_pixel;

	// byte taken whenever the queue has room
	assign in_stall = fifo_full;
	assign accept   = in_valid & ~fifo_full;
	assign last_bip = fmt.four_bytes ? BIP_ALPHA : BIP_RED;

	// header parse, pixel gather and packet bookkeeping
	always_comb begin
		left_n     = packet_left_q;
		repeat_n   = packet_repeat_q;
		awaiting_n = awaiting_q;
		bip_n      = bip_q;
		pixel_n    = pixel_q;
		pend_n     = restart_pend_q;
		alpha_c    = '0;
		count_c    = LEN_W'(1);
		done_pixel = 1'b0;

		if (first_byte) begin
			left_n     = '0;
			repeat_n   = 1'b0;
			awaiting_n = 1'b1;
			bip_n      = BIP_BLUE;
			pixel_n    = '0;
			pend_n     = 1'b1;
		end

		if (fmt.rle_mode && awaiting_n) begin
			repeat_n   = data_byte[7];
			left_n     = LEN_W'(data_byte[6:0] & PKT_LEN_MASK) + LEN_W'(1);
			awaiting_n = 1'b0;
			bip_n      = BIP_BLUE;
		end else begin
			unique case (bip_n)
				BIP_BLUE:  pixel_n[BYTE_W-1:0]          = data_byte;
				BIP_GREEN: pixel_n[2*BYTE_W-1:BYTE_W]   = data_byte;
				BIP_RED:   pixel_n[3*BYTE_W-1:2*BYTE_W] = data_byte;
				default:   alpha_c = data_byte;
			endcase
			if (bip_n < last_bip) begin
				bip_n = bip_n + BIP_W'(1);
			end else begin
				bip_n      = BIP_BLUE;
				done_pixel = 1'b1;
				if (fmt.rle_mode) begin
					if (repeat_n) begin
						count_c    = (left_n != '0) ? left_n : LEN_W'(1);
						left_n     = '0;
						awaiting_n = 1'b1;
					end else begin
						if (left_n != '0) begin
							left_n = left_n - LEN_W'(1);
						end
						if (left_n == '0) begin
							awaiting_n = 1'b1;
						end
					end
				end
			end
		end
	end

	// command toward the back end
	assign push             = accept & done_pixel;
	assign push_cmd.restart = pend_n;
	assign push_cmd.count   = count_c;
	assign push_cmd.red     = pixel_n[3*BYTE_W-1:2*BYTE_W];
	assign push_cmd.green   = pixel_n[2*BYTE_W-1:BYTE_W];
	assign push_cmd.blue    = pixel_n[BYTE_W-1:0];
	assign push_cmd.alpha   = alpha_c;

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_left_q   <= '0;
			packet_repeat_q <= 1'b0;
			awaiting_q      <= 1'b1;
			bip_q           <= BIP_BLUE;
			pixel_q         <= '0;
			restart_pend_q  <= 1'b0;
		end else if (accept) begin
			packet_left_q   <= left_n;
			packet_repeat_q <= repeat_n;
			awaiting_q      <= awaiting_n;
			bip_q           <= bip_n;
			pixel_q         <= pixel_n;
			restart_pend_q  <= pend_n & ~done_pixel;
		end
	end

endmodule

`default_nettype wire

/* design/tgapsd_cmd_fifo.sv */
`default_nettype none

module tgapsd_cmd_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire tgapsd_pkg::cmd_t  push_cmd,
	input  wire logic              pop,
	output tgapsd_pkg::cmd_t       head_cmd,
	output logic                   full,
	output logic                   empty
);
	import tgapsd_pkg::*;

	cmd_t                entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;
	logic                  do_push, do_pop;

	assign full     = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign head_cmd = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (FIFO_PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (FIFO_PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/tgapsd_back.sv */
`default_nettype none

module tgapsd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tgapsd_pkg::geom_t geom,
	input  wire tgapsd_pkg::cmd_t  head_cmd,
	input  wire logic              fifo_empty,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output tgapsd_pkg::res_t       res
);
	import tgapsd_pkg::*;

	logic                  active_q;
	cmd_t                  cmd_q;
	logic [LEN_W-1:0]      left_q;
	logic [POS_W-1:0]      column_q, col_a, col_n;
	logic [POS_W-1:0]      row_q, row_a, row_n;
	logic                  finished_q, fin_a, fin_n;
	logic                  out_valid_q;
	res_t                  res_q, res_c;
	logic                  slot_free, emit;
	logic [SIDE_W-1:0]     room, col_sum;
	logic [LEN_W-1:0]      span, left_n;
	logic [POS_W-1:0]      row_off;
	logic [POS_W+SIDE_W-1:0] row_base;
	logic                  done_c;

	assign slot_free = ~out_valid_q | ~out_stall;
	assign emit      = active_q & slot_free;
	assign pop       = ~active_q & ~fifo_empty;

	// one span per unstalled cycle: row wrap, clip to the row, mirrored address
	always_comb begin
		fin_a = finished_q | (SIDE_W'(row_q) >= geom.height);
		col_a = column_q;
		row_a = row_q;
		if (!fin_a && (SIDE_W'(column_q) >= geom.width)) begin
			col_a = '0;
			if ((SIDE_W'(row_q) + SIDE_W'(1)) >= geom.height) begin
				fin_a = 1'b1;
			end else begin
				row_a = row_q + POS_W'(1);
			end
		end

		room     = geom.width - SIDE_W'(col_a);
		span     = (room >= SIDE_W'(left_q)) ? left_q : LEN_W'(room);
		row_off  = POS_W'(geom.height - SIDE_W'(1) - SIDE_W'(row_a));
		row_base = row_off * geom.width;
		col_sum  = SIDE_W'(col_a) + SIDE_W'(span);
		left_n   = left_q - span;

		col_n  = col_a;
		row_n  = row_a;
		fin_n  = fin_a;
		done_c = 1'b0;
		if (!fin_a) begin
			if (col_sum >= geom.width) begin
				col_n = '0;
				if ((SIDE_W'(row_a) + SIDE_W'(1)) >= geom.height) begin
					fin_n  = 1'b1;
					done_c = 1'b1;
				end else begin
					row_n = row_a + POS_W'(1);
				end
			end else begin
				col_n = POS_W'(col_sum);
			end
		end

		res_c.red   = cmd_q.red;
		res_c.green = cmd_q.green;
		res_c.blue  = cmd_q.blue;
		res_c.alpha = cmd_q.alpha;
		if (fin_a) begin
			// dropped pixels past the image end
			res_c.start_address = '0;
			res_c.span_length   = left_q;
			res_c.last_of_run   = 1'b1;
			res_c.image_done    = 1'b0;
			res_c.overrun       = 1'b1;
		end else begin
			res_c.start_address = ADDR_W'(row_base) + ADDR_W'(col_a);
			res_c.span_length   = span;
			res_c.last_of_run   = (left_n == '0);
			res_c.image_done    = done_c;
			res_c.overrun       = 1'b0;
		end
	end

	// command and position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			left_q     <= '0;
			column_q   <= '0;
			row_q      <= '0;
			finished_q <= 1'b0;
		end else if (pop) begin
			active_q <= 1'b1;
			left_q   <= head_cmd.count;
			if (head_cmd.restart) begin
				column_q   <= '0;
				row_q      <= '0;
				finished_q <= 1'b0;
			end
		end else if (emit) begin
			column_q   <= col_n;
			row_q      <= row_n;
			finished_q <= fin_n;
			left_q     <= fin_a ? '0 : left_n;
			active_q   <= ~res_c.last_of_run;
		end
	end

	// colour of the command in flight
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head_cmd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_c;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

/* design/tga_pixel_stream_decoder_unit.sv */
`default_nettype none

// Decodes the pixel bytes of a truecolour image (raw, or run-length packets)
// into per-row spans of mirrored destination address, length and colour.
// A byte is taken every cycle while the four-entry command queue between the
// byte parser and the span generator has room; a pixel needs three or four
// bytes (plus a header byte per packet in run-length mode). The span
// generator loads one queued pixel group, then emits one span per cycle while
// the output is not stalled; the next group is loaded after the last span. A
// group gives one span normally, one more per destination row a repeat run
// crosses, and one for pixels dropped past the image end. Registers are taken
// (cfg_ready is always high) and may be written only while the block is idle.
module tga_pixel_stream_decoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [23:0]      start_address,
	output logic [7:0]       span_length,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       alpha,
	output logic             last_of_run,
	output logic             image_done,
	output logic             overrun
);
	import tgapsd_pkg::*;

	logic                  rle_mode_q;
	logic [BPP_W-1:0]      bpp_q;
	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;
	fmt_t                  fmt;
	geom_t                 geom;
	logic                  push, pop, fifo_full, fifo_empty;
	cmd_t                  push_cmd, head_cmd;
	res_t                  res;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rle_mode_q <= RST_RLE_MODE;
			bpp_q      <= RST_BPP;
			width_q    <= RST_WIDTH;
			height_q   <= RST_HEIGHT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RLE_MODE: rle_mode_q <= cfg_data[0];
				REG_BPP:      bpp_q      <= cfg_data[BPP_W-1:0];
				REG_WIDTH:    width_q    <= cfg_data;
				REG_HEIGHT:   height_q   <= cfg_data;
				default:      rle_mode_q <= rle_mode_q;
			endcase
		end
	end

	assign fmt.rle_mode   = rle_mode_q;
	assign fmt.four_bytes = (bpp_q == BPP_WITH_ALPHA);
	assign geom.width     = clamp_side(width_q, MIN_WIDTH);
	assign geom.height    = clamp_side(height_q, MIN_HEIGHT);

	tgapsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.fmt       (fmt),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.first_byte(first_byte),
		.fifo_full (fifo_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	tgapsd_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head_cmd(head_cmd),
		.full    (fifo_full),
		.empty   (fifo_empty)
	);

	tgapsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.head_cmd  (head_cmd),
		.fifo_empty(fifo_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	// result fields
	assign start_address = res.start_address;
	assign span_length   = res.span_length;
	assign red           = res.red;
	assign green         = res.green;
	assign blue          = res.blue;
	assign alpha         = res.alpha;
	assign last_of_run   = res.last_of_run;
	assign image_done    = res.image_done;
	assign overrun       = res.overrun;

endmodule

`default_nettype wire

/* design/tgapsd_checker.sv */
`default_nettype none

module tgapsd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [23:0] start_address,
	input wire logic [7:0]  span_length,
	input wire logic        last_of_run,
	input wire logic        image_done,
	input wire logic        overrun
);

	// a stalled request keeps its span
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(start_address)
			&& $stable(span_length) && $stable(last_of_run))
		else $error("stalled span changed");

	// span length stays within one packet
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> span_length != 8'd0 && span_length <= 8'd128)
		else $error("span length out of range");

	// dropped pixels close the pixel group and sit at address zero
	a_overrun_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overrun |-> last_of_run && !image_done && start_address == 24'd0)
		else $error("malformed overrun span");

	// the image end is a placed span, never a dropped one
	a_done_placed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> !overrun)
		else $error("image end flagged on dropped pixels");

endmodule

bind tga_pixel_stream_decoder_unit tgapsd_checker u_chk (.*);

`default_nettype wire

/* tb/tga_pixel_stream_decoder_unit_test.sv */
`default_nettype none

module tga_pixel_stream_decoder_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tgapsd_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_BYTES   = 10;
	localparam int RUN_LIMIT_NS  = 4_000_000;

	typedef enum bit {ROW_BYTE, ROW_REG} row_kind_t;

	// one line of the directed stimulus
	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [CFG_DATA_W-1:0]  reg_value;
		logic [BYTE_W-1:0]      byte_val;
		bit                     restart_flag;
		bit                     typed;
		logic [ADDR_W-1:0]      addr;
		logic [LEN_W-1:0]       len;
		bit                     over;
		bit                     done;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [BYTE_W-1:0]     data_byte;
	logic                  first_byte;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [ADDR_W-1:0]     start_address;
	logic [LEN_W-1:0]      span_length;
	logic [BYTE_W-1:0]     red;
	logic [BYTE_W-1:0]     green;
	logic [BYTE_W-1:0]     blue;
	logic [BYTE_W-1:0]     alpha;
	logic                  last_of_run;
	logic                  image_done;
	logic                  overrun;

	int send_idle_pct;
	int recv_stall_pct;
	int error_count;

	// register copies
	bit                    cfg_rle_mode;
	bit [BPP_W-1:0]        cfg_bpp_code;
	bit [CFG_DATA_W-1:0]   cfg_width_reg;
	bit [CFG_DATA_W-1:0]   cfg_height_reg;

	// decoder position and packet state
	int unsigned           pos_column;
	int unsigned           pos_row;
	bit [ADDR_W-1:0]       row_base;
	bit [7:0]              run_left;
	bit                    run_repeat;
	bit                    want_header;
	bit [BIP_W-1:0]        pixel_slot;
	bit [23:0]             gathered_bgr;
	bit                    image_full;

	res_t                  expected_spans[$];
	stim_row_t             directed_rows[$];

	tga_pixel_stream_decoder_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.start_address(start_address),
		.span_length  (span_length),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.last_of_run  (last_of_run),
		.image_done   (image_done),
		.overrun      (overrun)
	);

	always #(CLK_HALF) clk = ~clk;

	// random receiver backpressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("Regression FAIL");
		$finish;
	end

	function automatic int unsigned clamp_dim(bit [CFG_DATA_W-1:0] v, int unsigned lo);
		int unsigned r;
		r = v;
		if (r < lo) r = lo;
		if (r > MAX_SIDE) r = MAX_SIDE;
		return r;
	endfunction

	function automatic res_t colour_span(bit [ADDR_W-1:0] addr, int unsigned len,
		bit [7:0] a, bit done, bit over);
		res_t r;
		r.start_address = addr;
		r.span_length   = LEN_W'(len);
		r.red           = gathered_bgr[23:16];
		r.green         = gathered_bgr[15:8];
		r.blue          = gathered_bgr[7:0];
		r.alpha         = a;
		r.last_of_run   = 1'b0;
		r.image_done    = done;
		r.overrun       = over;
		return r;
	endfunction

	// split a pixel group into row spans, plus one span for dropped pixels
	function automatic void place_group(int unsigned count, bit [7:0] a);
		int unsigned w;
		int unsigned h;
		int unsigned left;
		int unsigned span;
		bit          done;
		bit          have_held;
		res_t        held;
		w = clamp_dim(cfg_width_reg, MIN_WIDTH);
		h = clamp_dim(cfg_height_reg, MIN_HEIGHT);
		left = count;
		have_held = 1'b0;
		while (left > 0) begin
			if (!image_full && pos_row >= h) image_full = 1'b1;
			if (!image_full && pos_column >= w) begin
				pos_column = 0;
				if (pos_row + 1 >= h) image_full = 1'b1;
				else pos_row++;
			end
			if (have_held) expected_spans.push_back(held);
			have_held = 1'b1;
			if (image_full) begin
				held = colour_span('0, left, a, 1'b0, 1'b1);
				left = 0;
			end else begin
				span = (left < w - pos_column) ? left : w - pos_column;
				done = 1'b0;
				row_base = ADDR_W'((h - 1 - pos_row) * w);
				held = colour_span(ADDR_W'(row_base + pos_column), span, a, 1'b0, 1'b0);
				pos_column += span;
				left -= span;
				if (pos_column >= w) begin
					pos_column = 0;
					if (pos_row + 1 >= h) begin
						image_full = 1'b1;
						done = 1'b1;
					end else begin
						pos_row++;
					end
				end
				held.image_done = done;
			end
		end
		if (have_held) begin
			held.last_of_run = 1'b1;
			expected_spans.push_back(held);
		end
	endfunction

	// advance the decoder by one accepted byte
	function automatic void decode_byte(bit [7:0] b, bit restart);
		int unsigned bpp;
		int unsigned count;
		bit [7:0]    a;
		bpp = (cfg_bpp_code == BPP_WITH_ALPHA) ? 4 : 3;
		a = '0;
		if (restart) begin
			pos_column   = 0;
			pos_row      = 0;
			run_left     = '0;
			run_repeat   = 1'b0;
			want_header  = 1'b1;
			pixel_slot   = BIP_BLUE;
			gathered_bgr = '0;
			image_full   = 1'b0;
		end
		if (cfg_rle_mode && want_header) begin
			run_repeat  = b[7];
			run_left    = {1'b0, b[6:0] & PKT_LEN_MASK} + 8'd1;
			want_header = 1'b0;
			pixel_slot  = BIP_BLUE;
			return;
		end
		if (pixel_slot == BIP_ALPHA) a = b;
		else gathered_bgr[int'(pixel_slot) * 8 +: 8] = b;
		if (int'(pixel_slot) + 1 < bpp) begin
			pixel_slot = pixel_slot + 1'b1;
			return;
		end
		pixel_slot = BIP_BLUE;
		if (!cfg_rle_mode) begin
			count = 1;
		end else if (run_repeat) begin
			count = (run_left != 0) ? run_left : 1;
			run_left = '0;
			want_header = 1'b1;
		end else begin
			count = 1;
			if (run_left > 0) run_left--;
			if (run_left == 0) want_header = 1'b1;
		end
		place_group(count, a);
	endfunction

	function automatic void byte_row(logic [7:0] d, bit f = 1'b0, bit typed = 1'b0,
		logic [23:0] addr = '0, logic [7:0] len = '0, bit over = 1'b0, bit done = 1'b0);
		stim_row_t r;
		r.kind         = ROW_BYTE;
		r.reg_idx      = '0;
		r.reg_value    = '0;
		r.byte_val     = d;
		r.restart_flag = f;
		r.typed        = typed;
		r.addr         = addr;
		r.len          = len;
		r.over         = over;
		r.done         = done;
		directed_rows.push_back(r);
	endfunction

	function automatic void reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		stim_row_t r;
		r.kind         = ROW_REG;
		r.reg_idx      = idx;
		r.reg_value    = v;
		r.byte_val     = '0;
		r.restart_flag = 1'b0;
		r.typed        = 1'b0;
		r.addr         = '0;
		r.len          = '0;
		r.over         = 1'b0;
		r.done         = 1'b0;
		directed_rows.push_back(r);
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got 0x%0h, want 0x%0h", what, got, want);
		error_count++;
	endtask

	// compare one accepted span against the oldest expectation
	task automatic check_span();
		res_t want;
		if (expected_spans.size() == 0) begin
			report_mismatch("span with nothing pending, address", start_address, 0);
		end else begin
			want = expected_spans.pop_front();
			if (start_address !== want.start_address)
				report_mismatch("start_address", start_address, want.start_address);
			if (span_length !== want.span_length)
				report_mismatch("span_length", span_length, want.span_length);
			if (red !== want.red) report_mismatch("red", red, want.red);
			if (green !== want.green) report_mismatch("green", green, want.green);
			if (blue !== want.blue) report_mismatch("blue", blue, want.blue);
			if (alpha !== want.alpha) report_mismatch("alpha", alpha, want.alpha);
			if (last_of_run !== want.last_of_run)
				report_mismatch("last_of_run", last_of_run, want.last_of_run);
			if (image_done !== want.image_done)
				report_mismatch("image_done", image_done, want.image_done);
			if (overrun !== want.overrun)
				report_mismatch("overrun", overrun, want.overrun);
		end
	endtask

	// outputs are settled at the falling edge, the request is taken at the next rise
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) check_span();
	end

	// one byte request, with random idle cycles ahead of it
	task automatic send_byte(logic [7:0] b, bit f);
		bit stalled;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		first_byte <= f;
		forever begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
			if (!stalled) break;
		end
		decode_byte(b, f);
	endtask

	// register write; the caller lowers cfg_valid after the last one
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		bit ready;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		forever begin
			@(negedge clk);
			ready = cfg_ready;
			@(posedge clk);
			if (ready) break;
		end
		unique case (idx)
			REG_RLE_MODE: cfg_rle_mode = v[0];
			REG_BPP:      cfg_bpp_code = v[BPP_W-1:0];
			REG_WIDTH:    cfg_width_reg = v;
			REG_HEIGHT:   cfg_height_reg = v;
		endcase
	endtask

	// hold off the sender until every span has come and the pipe is quiet
	task automatic drain_to_idle();
		in_valid <= 1'b0;
		while (expected_spans.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		stim_row_t   row;
		res_t        typed_span;
		int          sent;
		int unsigned npix;
		int unsigned bpp;
		bit          restart;
		logic [7:0]  hdr;
		logic [CFG_DATA_W-1:0] w_val;
		logic [CFG_DATA_W-1:0] h_val;

		// known values from time zero
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_RLE_MODE;
		cfg_data       = '0;
		in_valid       = 1'b0;
		data_byte      = '0;
		first_byte     = 1'b0;
		send_idle_pct  = 19;
		recv_stall_pct = 60;
		error_count    = 0;
		cfg_rle_mode   = RST_RLE_MODE;
		cfg_bpp_code   = RST_BPP;
		cfg_width_reg  = RST_WIDTH;
		cfg_height_reg = RST_HEIGHT;
		pos_column     = 0;
		pos_row        = 0;
		row_base       = '0;
		run_left       = '0;
		run_repeat     = 1'b0;
		want_header    = 1'b1;
		pixel_slot     = BIP_BLUE;
		gathered_bgr   = '0;
		image_full     = 1'b0;

		// directed rows: reset geometry first
		byte_row(8'h80, 1'b1);
		byte_row(8'h00);
		byte_row(8'h00);
		byte_row(8'h00, 1'b0, 1'b1, 24'd523264, 8'd1);
		byte_row(8'hFF);
		byte_row(8'hFF);
		byte_row(8'hFF);
		byte_row(8'hFF, 1'b0, 1'b1, 24'd523265, 8'd128);
		// smallest image, repeat run spills past the end
		reg_row(REG_WIDTH, 13'd4);
		reg_row(REG_HEIGHT, 13'd1);
		byte_row(8'h85, 1'b1);
		byte_row(8'h12);
		byte_row(8'h34);
		byte_row(8'h56, 1'b0, 1'b1, 24'd0, 8'd2, 1'b1, 1'b0);
		// largest image, raw four-byte pixels
		reg_row(REG_RLE_MODE, 13'd0);
		reg_row(REG_BPP, 13'd4);
		reg_row(REG_WIDTH, 13'd4096);
		reg_row(REG_HEIGHT, 13'd4096);
		byte_row(8'h01, 1'b1);
		byte_row(8'h02);
		byte_row(8'h03);
		byte_row(8'h04, 1'b0, 1'b1, 24'd16773120, 8'd1);
		// literal packet of two pixels with alpha
		reg_row(REG_RLE_MODE, 13'd1);
		byte_row(8'h01);
		byte_row(8'hA5);
		byte_row(8'h5A);
		byte_row(8'hC3);
		byte_row(8'h3C);
		byte_row(8'h00);
		byte_row(8'hFF);
		byte_row(8'h00);
		byte_row(8'hFF);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		for (int i = 0; i < directed_rows.size(); i++) begin
			row = directed_rows[i];
			if (row.kind == ROW_REG) begin
				if (i == 0 || directed_rows[i-1].kind != ROW_REG) drain_to_idle();
				write_reg(row.reg_idx, row.reg_value);
				if (i + 1 == directed_rows.size() || directed_rows[i+1].kind != ROW_REG)
					cfg_valid <= 1'b0;
			end else begin
				send_byte(row.byte_val, row.restart_flag);
				if (row.typed) begin
					typed_span = expected_spans.pop_back();
					typed_span.start_address = row.addr;
					typed_span.span_length   = row.len;
					typed_span.overrun       = row.over;
					typed_span.image_done    = row.done;
					expected_spans.push_back(typed_span);
				end
			end
		end

		// random phases, each with its own register setting
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			send_idle_pct  = (p < 2) ? 19 : (p < 4) ? 60 : 0;
			recv_stall_pct = (p < 2) ? 60 : (p < 4) ? 19 : 0;
			drain_to_idle();
			unique case (p)
				1: begin
					w_val = 13'h1FFF;
					h_val = 13'h0000;
				end
				3: begin
					w_val = 13'h0000;
					h_val = 13'h1FFF;
				end
				default: begin
					w_val = CFG_DATA_W'($urandom_range(4, 10));
					h_val = CFG_DATA_W'($urandom_range(1, 3));
				end
			endcase
			write_reg(REG_RLE_MODE, {(CFG_DATA_W-1)'($urandom_range(0, 4095)),
				1'($urandom_range(0, 3) != 0)});
			write_reg(REG_BPP, {(CFG_DATA_W-BPP_W)'($urandom_range(0, 1023)),
				(($urandom_range(0, 3) == 0) ? BPP_W'($urandom_range(0, 7))
				: ($urandom_range(0, 1) ? RST_BPP : BPP_WITH_ALPHA))});
			write_reg(REG_WIDTH, w_val);
			write_reg(REG_HEIGHT, h_val);
			cfg_valid <= 1'b0;
			bpp = (cfg_bpp_code == BPP_WITH_ALPHA) ? 4 : 3;
			restart = $urandom_range(0, 1);
			sent = 0;
			while (sent < PHASE_BYTES) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise, sometimes restarting mid-packet
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
					sent++;
				end else begin
					npix = 1;
					if (cfg_rle_mode) begin
						hdr[7] = $urandom_range(0, 1);
						if (hdr[7] && $urandom_range(0, 4) == 0)
							hdr[6:0] = 7'($urandom_range(0, 127));
						else
							hdr[6:0] = 7'($urandom_range(0, 3));
						send_byte(hdr, restart);
						restart = 1'b0;
						sent++;
						npix = hdr[7] ? 1 : int'(hdr[6:0]) + 1;
					end
					for (int k = 0; k < npix * bpp; k++) begin
						send_byte(8'($urandom_range(0, 255)), restart);
						restart = 1'b0;
						sent++;
					end
				end
			end
		end

		drain_to_idle();
		if (error_count == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
